// ===== hdl/lbgg_pkg.sv =====
// Shared types and constants for the LSTM backward gate-gradient datapath.
// Used by lbgg_round, lbgg_fp_op and the top level; depends on nothing.
`default_nettype none

package lbgg_pkg;

    localparam int FP_W     = 32;
    localparam int SEQ_W    = 16;
    localparam int RAW_W    = 52;
    localparam int EXP_W    = 12;
    localparam int BIAS     = 127;
    localparam int OP_LAT   = 4;
    localparam int N_LEVELS = 6;
    localparam int PIPE_LAT = N_LEVELS * OP_LAT;

    // Operation codes of the floating-point unit, selected per instance by its OP parameter.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_OMS = 2'd2;

    localparam logic [FP_W-1:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

    // Exact intermediate result: value = mant * 2^(expo - BIAS - (RAW_W - 1)).
    typedef struct packed {
        logic                    sign;
        logic                    nan;
        logic                    inf;
        logic signed [EXP_W-1:0] expo;
        logic [RAW_W-1:0]        mant;
    } raw_t;

endpackage

`default_nettype wire

// ===== hdl/lbgg_round.sv =====
// Normalize and round-to-nearest-even stage pair for the fp32 unit.
// Depends on lbgg_pkg (raw_t, widths, constants).
`default_nettype none

module lbgg_round (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire lbgg_pkg::raw_t  raw,
    output logic [31:0]          y
);
    import lbgg_pkg::*;

    localparam int LZ_W  = $clog2(RAW_W + 1);
    localparam int SH_W  = 6;
    localparam int SHW_W = RAW_W + 64;

    // Stage 1: leading-zero count and left normalization.
    logic [LZ_W-1:0] lz;
    logic            found;

    always_comb begin
        lz    = '0;
        found = 1'b0;
        for (int i = RAW_W - 1; i >= 0; i--) begin
            if (!found && raw.mant[i]) begin
                lz    = LZ_W'(RAW_W - 1 - i);
                found = 1'b1;
            end
        end
    end

    logic                    n1_sign_reg, n1_nan_reg, n1_inf_reg, n1_zero_reg;
    logic signed [EXP_W-1:0] n1_expo_reg;
    logic [RAW_W-1:0]        n1_mant_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_sign_reg <= raw.sign;
            n1_nan_reg  <= raw.nan;
            n1_inf_reg  <= raw.inf;
            n1_zero_reg <= !found;
            n1_expo_reg <= raw.expo - $signed({{(EXP_W-LZ_W){1'b0}}, lz});
            n1_mant_reg <= raw.mant << lz;
        end
    end

    // Stage 2: denormalizing shift for tiny results, rounding and packing.
    logic signed [EXP_W-1:0] rs_full, eb, ef;
    logic [SH_W-1:0]         rs;
    logic [SHW_W-1:0]        shw;
    logic [23:0]             keep, mfin;
    logic                    g, st;
    logic [24:0]             rnd;
    logic [31:0]             y_next;
    logic [31:0]             y_reg;

    always_comb begin
        if (n1_expo_reg < 1) begin
            rs_full = EXP_W'(1) - n1_expo_reg;
            eb      = EXP_W'(1);
        end else begin
            rs_full = '0;
            eb      = n1_expo_reg;
        end
        rs   = (rs_full > 63) ? SH_W'(63) : rs_full[SH_W-1:0];
        shw  = {n1_mant_reg, 64'b0} >> rs;
        keep = shw[SHW_W-1 -: 24];
        g    = shw[SHW_W-25];
        st   = |shw[SHW_W-26:0];
        rnd  = {1'b0, keep} + {24'b0, g & (st | keep[0])};
        if (rnd[24]) begin
            mfin = rnd[24:1];
            ef   = eb + EXP_W'(1);
        end else begin
            mfin = rnd[23:0];
            ef   = eb;
        end
        priority if (n1_nan_reg) begin
            y_next = FP_QNAN;
        end else if (n1_inf_reg) begin
            y_next = {n1_sign_reg, 8'hFF, 23'b0};
        end else if (n1_zero_reg) begin
            y_next = {n1_sign_reg, 31'b0};
        end else if (ef >= 255) begin
            y_next = {n1_sign_reg, 8'hFF, 23'b0};
        end else begin
            y_next = {n1_sign_reg, (mfin[23] ? ef[7:0] : 8'h00), mfin[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ===== hdl/lbgg_fp_op.sv =====
// Four-stage fp32 unit: multiply, add, or fused one-minus-square, all RNE.
// Depends on lbgg_pkg and lbgg_round.
`default_nettype none

module lbgg_fp_op #(
    parameter logic [1:0] OP = lbgg_pkg::OP_MUL
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);
    import lbgg_pkg::*;

    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [7:0]  expo;
        logic [23:0] mant;
    } fp_unp_t;

    typedef struct packed {
        logic                    nan;
        logic                    inf;
        logic                    isign;
        logic                    sa;
        logic signed [EXP_W-1:0] ea;
        logic [47:0]             ma;
        logic                    sb;
        logic signed [EXP_W-1:0] eb;
        logic [47:0]             mb;
    } op_pair_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] x);
        fp_unp_t u;
        u.sign = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'b0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'b0);
        u.zero = (x[30:0] == 31'b0);
        u.expo = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
        u.mant = {(x[30:23] != 8'h00), x[22:0]};
        return u;
    endfunction

    // Stage 1: unpack, and form the product where the operation needs one.
    fp_unp_t                 ua, ub;
    logic [47:0]             prod;
    logic signed [EXP_W-1:0] ex_a, ex_b;
    op_pair_t                s1_next, s1_reg;

    always_comb begin
        ua      = fp_unpack(a);
        ub      = fp_unpack((OP == OP_OMS) ? a : b);
        prod    = ua.mant * ub.mant;
        ex_a    = $signed({{(EXP_W-8){1'b0}}, ua.expo});
        ex_b    = $signed({{(EXP_W-8){1'b0}}, ub.expo});
        s1_next = '0;
        unique case (OP)
            OP_ADD: begin
                s1_next.nan   = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign != ub.sign));
                s1_next.inf   = ua.inf | ub.inf;
                s1_next.isign = ua.inf ? ua.sign : ub.sign;
                s1_next.sa    = ua.sign;
                s1_next.ea    = ex_a;
                s1_next.ma    = {ua.mant, 24'b0};
                s1_next.sb    = ub.sign;
                s1_next.eb    = ex_b;
                s1_next.mb    = {ub.mant, 24'b0};
            end
            OP_OMS: begin
                // One minus the exact square: the square enters as a negative addend.
                s1_next.nan   = ua.nan;
                s1_next.inf   = ua.inf;
                s1_next.isign = 1'b1;
                s1_next.sa    = 1'b0;
                s1_next.ea    = EXP_W'(BIAS);
                s1_next.ma    = {1'b1, 47'b0};
                s1_next.sb    = 1'b1;
                s1_next.eb    = (ex_a <<< 1) - EXP_W'(BIAS - 1);
                s1_next.mb    = prod;
            end
            default: begin
                s1_next.nan   = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
                s1_next.inf   = ua.inf | ub.inf;
                s1_next.isign = ua.sign ^ ub.sign;
                s1_next.sa    = ua.sign ^ ub.sign;
                s1_next.ea    = ex_a + ex_b - EXP_W'(BIAS - 1);
                s1_next.ma    = prod;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: align and add the two operands exactly enough for one rounding.
    logic signed [EXP_W-1:0] d, sh_full, e_big;
    logic [5:0]              sh;
    logic [47:0]             m_big, m_sml;
    logic                    s_big, s_sml;
    logic [111:0]            shw;
    logic [50:0]             big_al, sml_al;
    logic [52:0]             diff, ndiff;
    logic [RAW_W-1:0]        mag;
    logic                    neg;
    raw_t                    s2_next, s2_reg;

    always_comb begin
        d = s1_reg.ea - s1_reg.eb;
        if (d >= 0) begin
            e_big   = s1_reg.ea;
            m_big   = s1_reg.ma;
            s_big   = s1_reg.sa;
            m_sml   = s1_reg.mb;
            s_sml   = s1_reg.sb;
            sh_full = d;
        end else begin
            e_big   = s1_reg.eb;
            m_big   = s1_reg.mb;
            s_big   = s1_reg.sb;
            m_sml   = s1_reg.ma;
            s_sml   = s1_reg.sa;
            sh_full = -d;
        end
        sh     = (sh_full > 63) ? 6'd63 : sh_full[5:0];
        shw    = {m_sml, 64'b0} >> sh;
        sml_al = {shw[111:62], |shw[61:0]};
        big_al = {m_big, 3'b0};
        if (s_big == s_sml) begin
            diff = {2'b0, big_al} + {2'b0, sml_al};
        end else begin
            diff = {2'b0, big_al} - {2'b0, sml_al};
        end
        ndiff = -diff;
        neg   = diff[52];
        mag   = neg ? ndiff[RAW_W-1:0] : diff[RAW_W-1:0];

        s2_next.nan = s1_reg.nan;
        s2_next.inf = s1_reg.inf;
        if (OP == OP_MUL) begin
            s2_next.sign = s1_reg.sa;
            s2_next.expo = s1_reg.ea;
            s2_next.mant = {s1_reg.ma, 4'b0};
        end else begin
            if (s1_reg.inf) begin
                s2_next.sign = s1_reg.isign;
            end else if (mag == '0) begin
                s2_next.sign = s1_reg.sa & s1_reg.sb;
            end else begin
                s2_next.sign = s_big ^ neg;
            end
            s2_next.expo = e_big + EXP_W'(1);
            s2_next.mant = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s2_next;
        end
    end

    // Stages 3 and 4: normalize, round and pack.
    lbgg_round u_round (
        .aclk (aclk),
        .en   (en),
        .raw  (s2_reg),
        .y    (y)
    );

endmodule

`default_nettype wire

// ===== hdl/lstm_backward_gate_gradients.sv =====
// LSTM backward gate gradients, one fp32 element of each tensor per transaction.
// Built from six dependent levels of 4-stage fp32 units (multiply, add,
// fused one-minus-square). Throughput is one transaction per cycle; the whole
// pipeline advances together and holds while a finished result is not taken.
// Reset clears all valid bits and sets sequence_length to 1.
// Depends on lbgg_pkg and lbgg_fp_op.
`default_nettype none

module lstm_backward_gate_gradients (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_time_index,
    input  wire logic [31:0] s_out_grad,
    input  wire logic [31:0] s_hidden_grad,
    input  wire logic [31:0] s_out_gate,
    input  wire logic [31:0] s_cell_tanh,
    input  wire logic [31:0] s_cell_state_grad,
    input  wire logic [31:0] s_carried_cell_grad,
    input  wire logic [31:0] s_in_gate,
    input  wire logic [31:0] s_cand_input,
    input  wire logic [31:0] s_prev_cell,
    input  wire logic [31:0] s_forget_gate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_cand_grad,
    output logic [31:0]      m_in_gate_grad,
    output logic [31:0]      m_forget_gate_grad,
    output logic [31:0]      m_out_gate_grad,
    output logic [31:0]      m_cell_grad_out
);
    import lbgg_pkg::*;

    localparam int D1 = OP_LAT;
    localparam int D3 = 3 * OP_LAT;
    localparam int D4 = 4 * OP_LAT;

    // Configuration register.
    logic [SEQ_W-1:0] seq_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= SEQ_W'(1);
        end else if (cfg_wr_en) begin
            seq_len_reg <= cfg_wr_data;
        end
    end

    // Pipeline control: every stage moves unless the output is stalled.
    logic                en;
    logic [PIPE_LAT-1:0] vld_reg, vld_next;

    assign en       = !vld_reg[PIPE_LAT-1] || m_ready;
    assign s_ready  = en;
    assign m_valid  = vld_reg[PIPE_LAT-1];
    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_valid && s_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Final-timestep select, taken at the input.
    logic        last;
    logic [31:0] csel;

    assign last = (seq_len_reg != '0) && (s_time_index == (seq_len_reg - SEQ_W'(1)));
    assign csel = last ? s_cell_state_grad : s_carried_cell_grad;

    // Delay lines that carry operands to the level that uses them.
    logic [D1-1:0]        last_dly_reg;
    logic [D1-1:0][31:0]  dh_dly_reg, o_dly_reg, co_dly_reg, omsco_dly_reg, dcp_dly_reg;
    logic [D3-1:0][31:0]  csel_dly_reg, iiomi_dly_reg, ffm_dly_reg, dp_dly_reg;
    logic [D4-1:0][31:0]  ii_dly_reg, f_dly_reg, ci_dly_reg, cps_dly_reg, omsci_dly_reg;

    logic [31:0] gadd, oms_co, oms_ci, omii, omf, omo;
    logic [31:0] g, g_o, g_co, iiomi, ffm, oom;
    logic [31:0] t_val, dp_val, c_val;
    logic [31:0] ii_c, ci_c, cps_c, dcp_val;

    always_ff @(posedge aclk) begin
        if (en) begin
            last_dly_reg  <= {last_dly_reg[D1-2:0], last};
            dh_dly_reg    <= {dh_dly_reg[D1-2:0], s_hidden_grad};
            o_dly_reg     <= {o_dly_reg[D1-2:0], s_out_gate};
            co_dly_reg    <= {co_dly_reg[D1-2:0], s_cell_tanh};
            omsco_dly_reg <= {omsco_dly_reg[D1-2:0], oms_co};
            dcp_dly_reg   <= {dcp_dly_reg[D1-2:0], dcp_val};
            csel_dly_reg  <= {csel_dly_reg[D3-2:0], csel};
            iiomi_dly_reg <= {iiomi_dly_reg[D3-2:0], iiomi};
            ffm_dly_reg   <= {ffm_dly_reg[D3-2:0], ffm};
            dp_dly_reg    <= {dp_dly_reg[D3-2:0], dp_val};
            ii_dly_reg    <= {ii_dly_reg[D4-2:0], s_in_gate};
            f_dly_reg     <= {f_dly_reg[D4-2:0], s_forget_gate};
            ci_dly_reg    <= {ci_dly_reg[D4-2:0], s_cand_input};
            cps_dly_reg   <= {cps_dly_reg[D4-2:0], s_prev_cell};
            omsci_dly_reg <= {omsci_dly_reg[D4-2:0], oms_ci};
        end
    end

    // Level 1: hidden-gradient sum, fused squares and one-minus terms.
    lbgg_fp_op #(.OP(OP_ADD)) u_gadd (.aclk(aclk), .en(en), .a(s_out_grad),
        .b(s_hidden_grad), .y(gadd));
    lbgg_fp_op #(.OP(OP_OMS)) u_omsco (.aclk(aclk), .en(en), .a(s_cell_tanh),
        .b(32'b0), .y(oms_co));
    lbgg_fp_op #(.OP(OP_OMS)) u_omsci (.aclk(aclk), .en(en), .a(s_cand_input),
        .b(32'b0), .y(oms_ci));
    lbgg_fp_op #(.OP(OP_ADD)) u_omii (.aclk(aclk), .en(en), .a(FP_ONE),
        .b({~s_in_gate[31], s_in_gate[30:0]}), .y(omii));
    lbgg_fp_op #(.OP(OP_ADD)) u_omf (.aclk(aclk), .en(en), .a(FP_ONE),
        .b({~s_forget_gate[31], s_forget_gate[30:0]}), .y(omf));
    lbgg_fp_op #(.OP(OP_ADD)) u_omo (.aclk(aclk), .en(en), .a(FP_ONE),
        .b({~s_out_gate[31], s_out_gate[30:0]}), .y(omo));

    // Level 2: products with the hidden gradient and the gate derivatives.
    assign g = last_dly_reg[D1-1] ? dh_dly_reg[D1-1] : gadd;

    lbgg_fp_op #(.OP(OP_MUL)) u_go (.aclk(aclk), .en(en), .a(g),
        .b(o_dly_reg[D1-1]), .y(g_o));
    lbgg_fp_op #(.OP(OP_MUL)) u_gco (.aclk(aclk), .en(en), .a(g),
        .b(co_dly_reg[D1-1]), .y(g_co));
    lbgg_fp_op #(.OP(OP_MUL)) u_iiomi (.aclk(aclk), .en(en), .a(ii_dly_reg[D1-1]),
        .b(omii), .y(iiomi));
    lbgg_fp_op #(.OP(OP_MUL)) u_ffm (.aclk(aclk), .en(en), .a(f_dly_reg[D1-1]),
        .b(omf), .y(ffm));
    lbgg_fp_op #(.OP(OP_MUL)) u_oom (.aclk(aclk), .en(en), .a(o_dly_reg[D1-1]),
        .b(omo), .y(oom));

    // Level 3: cell-gradient increment and the output gate gradient.
    lbgg_fp_op #(.OP(OP_MUL)) u_t (.aclk(aclk), .en(en), .a(g_o),
        .b(omsco_dly_reg[D1-1]), .y(t_val));
    lbgg_fp_op #(.OP(OP_MUL)) u_dp (.aclk(aclk), .en(en), .a(g_co),
        .b(oom), .y(dp_val));

    // Level 4: cell gradient.
    lbgg_fp_op #(.OP(OP_ADD)) u_c (.aclk(aclk), .en(en), .a(csel_dly_reg[D3-1]),
        .b(t_val), .y(c_val));

    // Level 5: products with the cell gradient.
    lbgg_fp_op #(.OP(OP_MUL)) u_iic (.aclk(aclk), .en(en), .a(ii_dly_reg[D4-1]),
        .b(c_val), .y(ii_c));
    lbgg_fp_op #(.OP(OP_MUL)) u_cic (.aclk(aclk), .en(en), .a(ci_dly_reg[D4-1]),
        .b(c_val), .y(ci_c));
    lbgg_fp_op #(.OP(OP_MUL)) u_cpsc (.aclk(aclk), .en(en), .a(cps_dly_reg[D4-1]),
        .b(c_val), .y(cps_c));
    lbgg_fp_op #(.OP(OP_MUL)) u_dcp (.aclk(aclk), .en(en), .a(c_val),
        .b(f_dly_reg[D4-1]), .y(dcp_val));

    // Level 6: remaining gate gradients.
    lbgg_fp_op #(.OP(OP_MUL)) u_dci (.aclk(aclk), .en(en), .a(ii_c),
        .b(omsci_dly_reg[D4-1]), .y(m_cand_grad));
    lbgg_fp_op #(.OP(OP_MUL)) u_di (.aclk(aclk), .en(en), .a(iiomi_dly_reg[D3-1]),
        .b(ci_c), .y(m_in_gate_grad));
    lbgg_fp_op #(.OP(OP_MUL)) u_df (.aclk(aclk), .en(en), .a(ffm_dly_reg[D3-1]),
        .b(cps_c), .y(m_forget_gate_grad));

    assign m_out_gate_grad = dp_dly_reg[D3-1];
    assign m_cell_grad_out = dcp_dly_reg[D1-1];

    // A stalled result freezes the whole pipeline, input included.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while the result transaction is stalled");

    // NaN results always leave in canonical form.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cand_grad[30:23] == 8'hFF && m_cand_grad[22:0] != 23'b0)
        |-> (m_cand_grad == FP_QNAN))
        else $error("non-canonical NaN on cand_grad");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cell_grad_out[30:23] == 8'hFF && m_cell_grad_out[22:0] != 23'b0)
        |-> (m_cell_grad_out == FP_QNAN))
        else $error("non-canonical NaN on cell_grad_out");

    // Nothing is presented right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
